### rtl/core/dda_pkg.sv
`default_nettype none

package dda_pkg;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // capture endpoints, start a new segment
    logic div_step;  // one restoring division step on both axes
    logic pix_step;  // advance both positions by one increment
  } dda_cmd_t;

  // status from the datapath back to the sequencer
  typedef struct packed {
    logic steps_zero;  // segment has zero length
    logic last;        // current pixel is the final one
  } dda_sts_t;

endpackage

`default_nettype wire

### rtl/core/dda_ctrl.sv
`default_nettype none

module dda_ctrl #(
  parameter int unsigned DIV_LEN = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dda_pkg::dda_sts_t  sts_i,
  output dda_pkg::dda_cmd_t  cmd_o
);
  import dda_pkg::*;

  localparam int unsigned DivCntW = (DIV_LEN > 1) ? $clog2(DIV_LEN) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  dda_cmd_t           cmd;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd       = '0;
    case (state_q)
      ST_IDLE: begin
        div_cnt_d = '0;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        // zero length needs no increments, go straight to the start pixel
        if (sts_i.steps_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
          div_cnt_d    = div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(DIV_LEN - 1)) begin
            div_cnt_d = '0;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd.pix_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

### rtl/core/dda_dpath.sv
`default_nettype none

module dda_dpath #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  dda_pkg::dda_cmd_t     cmd_i,
  output dda_pkg::dda_sts_t     sts_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o
);
  import dda_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned W = COORD_BITS + FRAC_BITS;

  logic [C-1:0] adx, ady, steps;
  logic         negx, negy;

  logic [C-1:0] steps_q, cnt_q;
  logic         negx_q, negy_q;
  logic [W-1:0] posx_q, posy_q;
  logic [W-1:0] dvdx_q, dvdy_q;
  logic [C-1:0] remx_q, remy_q;
  logic [F:0]   qx_q, qy_q;

  logic [C:0]   tx, ty, subx, suby;
  logic         gex, gey;
  logic [W-1:0] incx, incy;
  dda_sts_t     sts;

  assign negx  = (end_x_i < start_x_i);
  assign negy  = (end_y_i < start_y_i);
  assign adx   = negx ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
  assign ady   = negy ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
  assign steps = (ady > adx) ? ady : adx;

  // restoring division, one quotient bit per axis each cycle
  assign tx   = {remx_q, dvdx_q[W-1]};
  assign ty   = {remy_q, dvdy_q[W-1]};
  assign gex  = (tx >= {1'b0, steps_q});
  assign gey  = (ty >= {1'b0, steps_q});
  assign subx = tx - {1'b0, steps_q};
  assign suby = ty - {1'b0, steps_q};

  assign incx = W'(qx_q);
  assign incy = W'(qy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steps_q <= steps;
      cnt_q   <= steps;
      negx_q  <= negx;
      negy_q  <= negy;
      // positions carry the rounding half so the pixel is a plain select
      posx_q  <= {start_x_i, 1'b1, {(F-1){1'b0}}};
      posy_q  <= {start_y_i, 1'b1, {(F-1){1'b0}}};
      dvdx_q  <= {adx, {F{1'b0}}};
      dvdy_q  <= {ady, {F{1'b0}}};
      remx_q  <= '0;
      remy_q  <= '0;
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (cmd_i.div_step) begin
      dvdx_q <= {dvdx_q[W-2:0], 1'b0};
      dvdy_q <= {dvdy_q[W-2:0], 1'b0};
      remx_q <= gex ? subx[C-1:0] : tx[C-1:0];
      remy_q <= gey ? suby[C-1:0] : ty[C-1:0];
      qx_q   <= {qx_q[F-1:0], gex};
      qy_q   <= {qy_q[F-1:0], gey};
    end else if (cmd_i.pix_step) begin
      posx_q <= negx_q ? (posx_q - incx) : (posx_q + incx);
      posy_q <= negy_q ? (posy_q - incy) : (posy_q + incy);
      cnt_q  <= cnt_q - C'(1);
    end
  end

  always_comb begin
    sts            = '0;
    sts.steps_zero = (steps_q == '0);
    sts.last       = (cnt_q == '0);
  end

  assign sts_o     = sts;
  assign pixel_x_o = posx_q[W-1:F];
  assign pixel_y_o = posy_q[W-1:F];

endmodule

`default_nettype wire

### rtl/core/dda_line_rasterizer.sv
// DDA line rasterizer
//
// Input channel (in_valid_i / in_ready_o) takes one segment: start and end
// points in a 2^COORD_BITS square tile. Output channel (out_valid_o /
// out_ready_i) gives its pixels, start pixel first, one per step, with
// last_pixel_o high on the final one. A segment of steps = max(|dx|,|dy|)
// gives steps + 1 pixels; a zero-length segment gives only the start pixel.
//
// After an item is taken the per-axis increments come from a restoring
// divider that produces one quotient bit per cycle for both axes; it is
// skipped for a zero-length segment. Pixels then leave at one per cycle
// while the receiver is ready. One segment is in flight at a time: the
// input is ready again in the cycle after the last pixel is accepted.
//
// Reset returns the sequencer to idle with no pixel pending. When the
// receiver stalls the current pixel is held unchanged and the walk pauses.
`default_nettype none

module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 6,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;

  dda_ctrl #(
    .DIV_LEN(COORD_BITS + FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dda_dpath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .pixel_x_o(pixel_x_o),
    .pixel_y_o(pixel_y_o)
  );

  assign last_pixel_o = sts.last;

endmodule

`default_nettype wire

### rtl/core/dda_checker.sv
`default_nettype none

module dda_checker #(
  parameter int unsigned COORD_BITS = 6
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wire [COORD_BITS-1:0] pixel_x_o,
  input wire [COORD_BITS-1:0] pixel_y_o,
  input wire                  last_pixel_o
);

  // one segment at a time: never taking an item while pixels are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a pixel is pending");

  // a pixel never shows in the cycle right after an item is taken
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("pixel too early after item");

  // the final pixel frees the input side
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_pixel_o) |=> in_ready_o)
    else $error("not idle after last pixel");

  // an inner pixel is followed directly by the next one
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_pixel_o) |=> out_valid_o)
    else $error("pixel stream broke before last pixel");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_pixel_o)))
    else $error("stalled pixel changed");

endmodule

bind dda_line_rasterizer dda_checker #(
  .COORD_BITS(COORD_BITS)
) u_dda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_x_o   (pixel_x_o),
  .pixel_y_o   (pixel_y_o),
  .last_pixel_o(last_pixel_o)
);

`default_nettype wire

### tb/sv/dda_line_rasterizer_tb.sv
module dda_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_t expected_pixels[$];
  bit     failed = 1'b0;
  bit     idle_en = 1'b1;
  int     ready_stall = 0;
  int     quiet_cycles = 0;

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

  always #10 clk_i = ~clk_i;

  // per-axis slope in fixed point, truncated magnitude with the sign applied
  function automatic logic [63:0] axis_increment(input coord_t from, input coord_t to,
                                                 input logic [63:0] steps);
    logic [63:0] mag;
    if (to >= from) begin
      mag = (64'(to - from) << FRAC_BITS) / steps;
      return mag;
    end
    mag = (64'(from - to) << FRAC_BITS) / steps;
    return 64'd0 - mag;
  endfunction

  function automatic coord_t round_coord(input logic [63:0] pos);
    logic [63:0] rounded;
    rounded = (pos + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return rounded[COORD_BITS-1:0];
  endfunction

  function automatic void predict_pixels(input coord_t sx, input coord_t sy,
                                         input coord_t ex, input coord_t ey);
    logic [63:0] adx;
    logic [63:0] ady;
    logic [63:0] steps;
    logic [63:0] incx;
    logic [63:0] incy;
    logic [63:0] posx;
    logic [63:0] posy;
    pixel_t      pix;
    adx = (ex >= sx) ? 64'(ex - sx) : 64'(sx - ex);
    ady = (ey >= sy) ? 64'(ey - sy) : 64'(sy - ey);
    steps = (ady > adx) ? ady : adx;
    pix.x = sx;
    pix.y = sy;
    pix.last = (steps == 0);
    expected_pixels.push_back(pix);
    if (steps == 0) return;
    incx = axis_increment(sx, ex, steps);
    incy = axis_increment(sy, ey, steps);
    posx = 64'(sx) << FRAC_BITS;
    posy = 64'(sy) << FRAC_BITS;
    for (longint unsigned i = 0; i < steps; i++) begin
      posx += incx;
      posy += incy;
      pix.x = round_coord(posx);
      pix.y = round_coord(posy);
      pix.last = (i + 1 == steps);
      expected_pixels.push_back(pix);
    end
  endfunction

  // valid stays high after acceptance until the next call lowers it or reloads it
  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixels(sx, sy, ex, ey);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t near_coord(input coord_t base);
    int v;
    v = int'(base) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > int'(COORD_MAX)) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic send_random_segment();
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     kind;
    sx = coord_t'($urandom_range(0, COORD_MAX));
    sy = coord_t'($urandom_range(0, COORD_MAX));
    ex = coord_t'($urandom_range(0, COORD_MAX));
    ey = coord_t'($urandom_range(0, COORD_MAX));
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      ex = near_coord(sx);
      ey = near_coord(sy);
    end else if (kind == 3) begin
      ex = sx;
      ey = sy;
    end else if (kind == 4) begin
      ey = sy;
    end else if (kind == 5) begin
      ex = sx;
    end
    send_segment(sx, sy, ex, ey);
  endtask

  task automatic test_directed();
    send_segment(6'd0, 6'd0, 6'd0, 6'd0);
    send_segment(6'd63, 6'd63, 6'd63, 6'd63);
    send_segment(6'd21, 6'd42, 6'd21, 6'd42);
    send_segment(6'd0, 6'd0, 6'd63, 6'd63);
    send_segment(6'd63, 6'd63, 6'd0, 6'd0);
    send_segment(6'd63, 6'd0, 6'd0, 6'd63);
    send_segment(6'd0, 6'd63, 6'd63, 6'd0);
    send_segment(6'd0, 6'd5, 6'd63, 6'd5);
    send_segment(6'd63, 6'd40, 6'd0, 6'd40);
    send_segment(6'd7, 6'd0, 6'd7, 6'd63);
    send_segment(6'd30, 6'd63, 6'd30, 6'd0);
    send_segment(6'd0, 6'd0, 6'd63, 6'd1);
    send_segment(6'd0, 6'd0, 6'd1, 6'd63);
    send_segment(6'd0, 6'd0, 6'd63, 6'd31);
    send_segment(6'd0, 6'd0, 6'd63, 6'd32);
    send_segment(6'd10, 6'd10, 6'd11, 6'd11);
    send_segment(6'd10, 6'd10, 6'd9, 6'd9);
    send_segment(6'd0, 6'd0, 6'd2, 6'd1);
    send_segment(6'd5, 6'd7, 6'd3, 6'd60);
    send_segment(6'd42, 6'd21, 6'd21, 6'd42);
  endtask

  task automatic test_random_segments();
    for (int n = 0; n < 150; n++) begin
      // alternate stretches with and without idling
      if (n % 30 == 0) idle_en = (n % 60 == 0);
      send_random_segment();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (4) send_random_segment();
    wait_drained();
    send_segment(6'd63, 6'd0, 6'd0, 6'd63);
    repeat (4) send_random_segment();
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (20) send_random_segment();
  endtask

  always @(posedge clk_i) begin
    if (ready_stall > 0) begin
      out_ready_i <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      ready_stall <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: x %0d y %0d last %0b",
               pixel_x_o, pixel_y_o, last_pixel_o);
        failed = 1'b1;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_x_o !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pixel_x_o);
          failed = 1'b1;
        end
        if (pixel_y_o !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pixel_y_o);
          failed = 1'b1;
        end
        if (last_pixel_o !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, last_pixel_o);
          failed = 1'b1;
        end
      end
    end
  end

  // counts cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("dda_line_rasterizer_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_segments();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_pixels.size() == 0) begin
      $display("dda_line_rasterizer_tb: PASS");
    end else begin
      $display("dda_line_rasterizer_tb: FAIL");
    end
    $finish;
  end

endmodule
